/* hdl/polyphonic_decay_tone_synth_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the decaying tone synthesiser
// Shared property wrappers: clocked on the rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_DECAY_TONE_SYNTH_MACROS_SVH
`define POLYPHONIC_DECAY_TONE_SYNTH_MACROS_SVH

// Same-cycle implication
`define PDTS_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("pdts: same-cycle check failed");

// Next-cycle implication
`define PDTS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("pdts: next-cycle check failed");

`endif

/* hdl/pdts_pkg.sv */
// ----------------------------------------------------------------------------
// pdts_pkg
// Shared constants, codes and control structs of the decaying tone synthesiser.
// ----------------------------------------------------------------------------
`default_nettype none

package pdts_pkg;

  // Voice and tone configuration
  localparam int NUM_VOICES  = 14;
  localparam int SAMPLE_RATE = 8000;
  localparam int PHASE_BITS  = 24;
  localparam int SINE_DEPTH  = 1024;

  localparam int VOICE_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH);

  // Datapath widths
  localparam int ENV_W       = 31;
  localparam int SINE_W      = 16;
  localparam int DECAY_W     = 16;
  localparam int SAMPLE_W    = 32;
  localparam int OPA_W       = ENV_W + 1;
  localparam int OPB_W       = ((DECAY_W > SINE_W) ? DECAY_W : SINE_W) + 1;
  localparam int PROD_W      = OPA_W + OPB_W;
  localparam int ACC_W       = SAMPLE_W + VOICE_W;
  localparam int SINE_FRAC_W = SINE_W - 1;

  // Stream payload widths
  localparam int IN_TDATA_W = 16;
  localparam int KEY_CODE_W = 8;
  localparam int KEY_STATE_W = 2;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = ENV_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRIKE_LEVEL,
    REG_DECAY_FACTOR
  } cfg_reg_t;

  localparam logic [ENV_W-1:0]   STRIKE_RESET = ENV_W'(165191049);
  localparam logic [DECAY_W-1:0] DECAY_RESET  = DECAY_W'(65516);

  // Request kinds and key states
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEY  = 1'b1;
  localparam logic [KEY_STATE_W-1:0] KEY_PRESSED = KEY_STATE_W'(1);

  // Scan code rows mapped onto voices
  localparam logic [KEY_CODE_W-1:0] KEY_ROW_A_FIRST = KEY_CODE_W'(3);
  localparam logic [KEY_CODE_W-1:0] KEY_ROW_A_LAST  = KEY_CODE_W'(8);
  localparam logic [KEY_CODE_W-1:0] KEY_ROW_B_FIRST = KEY_CODE_W'(16);
  localparam logic [KEY_CODE_W-1:0] KEY_ROW_B_LAST  = KEY_CODE_W'(23);
  localparam logic [KEY_CODE_W-1:0] ROW_B_VOICE0    = KEY_CODE_W'(6);

  typedef logic [VOICE_W-1:0] voice_idx_t;

  localparam voice_idx_t LAST_VOICE = voice_idx_t'(NUM_VOICES - 1);

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic sel_decay;
    logic acc_clr;
    logic acc_add;
  } mac_ctl_t;

  // Control of the voice state bank
  typedef struct packed {
    logic       key_we;
    voice_idx_t key_idx;
    logic       env_we;
    voice_idx_t env_widx;
    voice_idx_t env_ridx;
    logic       ph_adv;
    voice_idx_t ph_idx;
  } bank_ctl_t;

endpackage

`default_nettype wire

/* hdl/polyphonic_decay_tone_synth.sv */
// ----------------------------------------------------------------------------
// polyphonic_decay_tone_synth: 14-voice decaying sine synthesiser
// Tick: two shared-multiplier passes per voice, then the voice sum goes to the output
// register; next request taken once it is loaded, which waits for a free output register.
// Key request: written in its accept cycle, no result; next request accepted straight after.
// Sync reset: envelopes, phases, config defaults, sequencer and output clear.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyphonic_decay_tone_synth_macros.svh"

module polyphonic_decay_tone_synth (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input request stream
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  input  wire logic [pdts_pkg::IN_TDATA_W-1:0]     in_tdata,  // key_code[7:0], key_state[9:8]
  input  wire logic                                in_tuser,  // operation[0]
  // Result stream
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  output      logic [pdts_pkg::SAMPLE_W-1:0]       out_tdata, // audio_sample[31:0]
  // Configuration writes
  input  wire logic                                cfg_we,
  input  wire logic [pdts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pdts_pkg::CFG_W-1:0]          cfg_wdata
);
  import pdts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_S,
    ST_MUL_D,
    ST_FIN
  } state_t;

  state_t               state_r, state_nxt;
  voice_idx_t           voice_r, voice_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [SAMPLE_W-1:0]  out_tdata_r, out_tdata_nxt;
  logic [ENV_W-1:0]     strike_r;
  logic [DECAY_W-1:0]   decay_r;

  mac_ctl_t             mac_ctl;
  bank_ctl_t            bank_ctl;
  logic [ENV_W-1:0]     env_rd;
  logic [ENV_W-1:0]     env_dec;
  logic [SINE_IDX_W-1:0] sine_addr;
  logic signed [SINE_W-1:0] sine;
  logic [SAMPLE_W-1:0]  sample;

  logic                   in_accept;
  logic [KEY_CODE_W-1:0]  key_code;
  logic [KEY_STATE_W-1:0] key_state;
  logic [KEY_CODE_W-1:0]  key_slot;
  logic                   key_row_hit;
  logic                   key_hit;

  assign in_accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign key_code  = in_tdata[KEY_CODE_W-1:0];
  assign key_state = in_tdata[KEY_CODE_W +: KEY_STATE_W];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strike_r <= STRIKE_RESET;
      decay_r  <= DECAY_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STRIKE_LEVEL: strike_r <= cfg_wdata;
        REG_DECAY_FACTOR: decay_r  <= cfg_wdata[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Scan code to voice
  always_comb begin
    key_row_hit = 1'b0;
    key_slot    = '0;
    if (key_code inside {[KEY_ROW_A_FIRST:KEY_ROW_A_LAST]}) begin
      key_row_hit = 1'b1;
      key_slot    = key_code - KEY_ROW_A_FIRST;
    end else if (key_code inside {[KEY_ROW_B_FIRST:KEY_ROW_B_LAST]}) begin
      key_row_hit = 1'b1;
      key_slot    = key_code - KEY_ROW_B_FIRST + ROW_B_VOICE0;
    end
    key_hit = key_row_hit && (key_state == KEY_PRESSED) && (key_slot < NUM_VOICES);
  end

  // Sequencer: per voice a sine product then a decay product
  always_comb begin
    state_nxt      = state_r;
    voice_nxt      = voice_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    mac_ctl        = '0;
    bank_ctl       = '0;
    bank_ctl.key_idx  = key_slot[VOICE_W-1:0];
    bank_ctl.env_ridx = voice_r;
    bank_ctl.env_widx = voice_r;
    bank_ctl.ph_idx   = voice_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_tuser == OP_TICK) begin
            state_nxt = ST_PREP;
            voice_nxt = '0;
          end else begin
            bank_ctl.key_we = key_hit;
          end
        end
      end
      ST_PREP: begin
        bank_ctl.ph_adv = 1'b1;
        bank_ctl.ph_idx = '0;
        mac_ctl.acc_clr = 1'b1;
        state_nxt       = ST_MUL_S;
      end
      ST_MUL_S: begin
        mac_ctl.mul_en = 1'b1;
        // previous voice's decayed envelope goes back
        if (voice_r != '0) begin
          bank_ctl.env_we   = 1'b1;
          bank_ctl.env_widx = voice_r - 1'b1;
        end
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        mac_ctl.mul_en    = 1'b1;
        mac_ctl.sel_decay = 1'b1;
        mac_ctl.acc_add   = 1'b1;
        if (voice_r != LAST_VOICE) begin
          // fetch sine for next voice and step its phase
          bank_ctl.ph_adv = 1'b1;
          bank_ctl.ph_idx = voice_r + 1'b1;
          voice_nxt       = voice_r + 1'b1;
          state_nxt       = ST_MUL_S;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        bank_ctl.env_we = 1'b1;
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt  = sample;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      voice_r      <= '0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      voice_r      <= voice_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      out_tdata_r  <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  pdts_voice_bank u_bank (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (bank_ctl),
    .strike_level (strike_r),
    .env_wdata    (env_dec),
    .env_rd       (env_rd),
    .sine_addr    (sine_addr)
  );

  pdts_sine_rom u_rom (
    .clk    (clk),
    .rd_en  (bank_ctl.ph_adv),
    .addr   (sine_addr),
    .sine_r (sine)
  );

  pdts_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .env     (env_rd),
    .sine    (sine),
    .decay   (decay_r),
    .env_dec (env_dec),
    .sample  (sample)
  );

  // Checks
  `PDTS_ASSERT_NEXT(a_tick_starts, clk, rst_n, in_accept && (in_tuser == OP_TICK), state_r == ST_PREP)
  `PDTS_ASSERT_NEXT(a_key_no_run, clk, rst_n, in_accept && (in_tuser == OP_KEY), state_r == ST_IDLE)
  `PDTS_ASSERT_NOW(a_result_from_fin, clk, rst_n, $rose(out_tvalid_r), $past(state_r) == ST_FIN)
  `PDTS_ASSERT_NOW(a_voice_range, clk, rst_n, state_r != ST_IDLE, voice_r <= LAST_VOICE)

endmodule

`default_nettype wire

/* hdl/pdts_sine_rom.sv */
// ----------------------------------------------------------------------------
// pdts_sine_rom
// Full-wave Q1.15 sine table, built at elaboration, with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pdts_sine_rom (
  input  wire logic                                   clk,
  input  wire logic                                   rd_en,
  input  wire logic [pdts_pkg::SINE_IDX_W-1:0]        addr,
  output      logic signed [pdts_pkg::SINE_W-1:0]     sine_r
);
  import pdts_pkg::*;

  typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_DEPTH];

  localparam longint Q30 = longint'(1) <<< 30;

  // Ninth-order odd polynomial over a quarter turn, r in Q14
  function automatic longint quarter_sine(input longint r);
    longint u;
    longint u2;
    longint p;
    longint s;
    longint v;
    u  = r * 65536;
    u2 = (u * u) / Q30;
    p  = 172272;
    p  = -5026995 + (p * u2) / Q30;
    p  = 85569306 + (p * u2) / Q30;
    p  = -693598668 + (p * u2) / Q30;
    p  = 1686629713 + (p * u2) / Q30;
    s  = (p * u) / Q30;
    v  = (s * 32767 + Q30 / 2) / Q30;
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  // Quarter-wave folding into the full table
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint    t;
    longint    quad;
    longint    r;
    longint    v;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      t    = (longint'(i) * 65536) / SINE_DEPTH;
      quad = (t >> 14) & 3;
      r    = t & 16383;
      if (quad == 1 || quad == 3) r = 16384 - r;
      v = quarter_sine(r);
      if (quad >= 2) v = -v;
      tab[i] = SINE_W'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      sine_r <= SINE_TAB[addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/pdts_voice_bank.sv */
// ----------------------------------------------------------------------------
// pdts_voice_bank
// Per-voice envelope and phase registers with fixed note increments.
// ----------------------------------------------------------------------------
`default_nettype none

module pdts_voice_bank (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pdts_pkg::bank_ctl_t               ctl,
  input  wire logic [pdts_pkg::ENV_W-1:0]        strike_level,
  input  wire logic [pdts_pkg::ENV_W-1:0]        env_wdata,
  output      logic [pdts_pkg::ENV_W-1:0]        env_rd,
  output      logic [pdts_pkg::SINE_IDX_W-1:0]   sine_addr
);
  import pdts_pkg::*;

  typedef logic [PHASE_BITS-1:0] inc_tab_t [NUM_VOICES];

  localparam longint NOTE_DEN = longint'(SAMPLE_RATE) * 1000;

  // Note frequencies in millihertz; voice 2 is silent
  function automatic longint note_mhz(input int v);
    case (v)
      0:       return 277183;
      1:       return 311127;
      3:       return 369994;
      4:       return 415305;
      5:       return 466164;
      6:       return 261626;
      7:       return 293665;
      8:       return 329628;
      9:       return 349228;
      10:      return 391995;
      11:      return 440000;
      12:      return 493883;
      13:      return 523251;
      default: return 0;
    endcase
  endfunction

  // Rounded phase increments per sample
  function automatic inc_tab_t build_inc();
    inc_tab_t tab;
    longint   f;
    for (int v = 0; v < NUM_VOICES; v++) begin
      f      = note_mhz(v);
      tab[v] = PHASE_BITS'(((f << PHASE_BITS) + NOTE_DEN / 2) / NOTE_DEN);
    end
    return tab;
  endfunction

  localparam inc_tab_t NOTE_INC = build_inc();

  logic [ENV_W-1:0]      env_r   [NUM_VOICES];
  logic [PHASE_BITS-1:0] phase_r [NUM_VOICES];

  // Envelope and phase updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        env_r[v]   <= '0;
        phase_r[v] <= '0;
      end
    end else begin
      if (ctl.key_we) begin
        env_r[ctl.key_idx] <= strike_level;
      end
      if (ctl.env_we) begin
        env_r[ctl.env_widx] <= env_wdata;
      end
      if (ctl.ph_adv) begin
        phase_r[ctl.ph_idx] <= phase_r[ctl.ph_idx] + NOTE_INC[ctl.ph_idx];
      end
    end
  end

  // Read ports
  assign env_rd    = env_r[ctl.env_ridx];
  assign sine_addr = phase_r[ctl.ph_idx][PHASE_BITS-1 -: SINE_IDX_W];

endmodule

`default_nettype wire

/* hdl/pdts_mac.sv */
// ----------------------------------------------------------------------------
// pdts_mac
// Shared multiplier with sample accumulator and 32-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module pdts_mac (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire pdts_pkg::mac_ctl_t                   ctl,
  input  wire logic [pdts_pkg::ENV_W-1:0]           env,
  input  wire logic signed [pdts_pkg::SINE_W-1:0]   sine,
  input  wire logic [pdts_pkg::DECAY_W-1:0]         decay,
  output      logic [pdts_pkg::ENV_W-1:0]           env_dec,
  output      logic [pdts_pkg::SAMPLE_W-1:0]        sample
);
  import pdts_pkg::*;

  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] term_full;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_r;
  logic [ACC_W-SAMPLE_W:0]  acc_hi;

  // Operand select: sine term or decay factor
  assign op_a     = $signed({1'b0, env});
  assign op_b     = ctl.sel_decay ? $signed({1'b0, decay}) : OPB_W'(sine);
  assign prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Divide by 2^15 rounding toward zero
  assign term_full = prod_r[PROD_W-1]
                   ? (prod_r + PROD_W'(2 ** SINE_FRAC_W - 1)) >>> SINE_FRAC_W
                   : prod_r >>> SINE_FRAC_W;
  assign term      = $signed(term_full[ACC_W-1:0]);

  // Voice sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.acc_add) begin
      acc_r <= acc_r + term;
    end
  end

  // Envelope after decay, Q0.16 truncation
  assign env_dec = prod_r[DECAY_W +: ENV_W];

  // Saturate to 32-bit signed
  assign acc_hi = acc_r[ACC_W-1:SAMPLE_W-1];
  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      sample = acc_r[SAMPLE_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the fourteen-voice decaying tone synthesiser
// A directed table, then phases of random key and tick requests under several
// strike and decay settings. Each sample is checked against a bit-exact
// predictor; both stream sides idle and stall, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import pdts_pkg::*;

  localparam int PERIOD_HALF  = 2;
  localparam int RESET_CYCLES = 11;
  localparam int SETTLE       = 40;     // margin for a tick still in flight
  localparam int WATCHDOG     = 4000;   // cycles without any handshake
  localparam int HOLD_AT      = 3000;   // earliest receiver cycle of the long hold-off
  localparam int HOLD_LEN     = 400;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 280;
  localparam int PLAN_LEN     = 28;
  localparam int MAX_PRINTS   = 20;

  localparam logic [KEY_STATE_W-1:0] KEY_RELEASED = KEY_STATE_W'(0);
  localparam logic [KEY_STATE_W-1:0] KEY_REPEAT   = KEY_STATE_W'(2);

  localparam longint Q30 = 64'sd1073741824;
  localparam int unsigned NOTE_MHZ [NUM_VOICES] = '{
    277183, 311127, 0, 369994, 415305, 466164, 261626,
    293665, 329628, 349228, 391995, 440000, 493883, 523251
  };

  // One line of the directed plan: a register write or a request
  typedef struct packed {
    logic                    is_reg;
    cfg_reg_t                sel;
    logic [ENV_W-1:0]        wval;
    logic                    op;
    logic [KEY_CODE_W-1:0]   code;
    logic [KEY_STATE_W-1:0]  kstate;
    logic                    zero_known;   // sample is plainly zero
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;   // key_code[7:0], key_state[9:8]
  logic in_tuser;                    // operation[0]
  logic out_tvalid;
  logic out_tready;
  logic [SAMPLE_W-1:0] out_tdata;    // audio_sample[31:0]
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  // Predictor state
  int                 sine_q15 [SINE_DEPTH];
  logic [ENV_W-1:0]   env_lvl [NUM_VOICES];
  logic [PHASE_BITS-1:0] phase_acc [NUM_VOICES];
  logic [PHASE_BITS-1:0] note_step [NUM_VOICES];
  logic [ENV_W-1:0]   strike_cfg;
  logic [DECAY_W-1:0] decay_cfg;
  logic [SAMPLE_W-1:0] sample_q [$];

  // Bookkeeping
  int errors, samples_checked, saturations, ticks_sent, keys_sent, voices_struck;
  int reg_writes, burst_left, idle_cycles, rx_cycle, hold_left;
  logic hold_done;
  logic [SAMPLE_W-1:0] want;
  step_row_t plan [PLAN_LEN];

  polyphonic_decay_tone_synth dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #PERIOD_HALF clk = 1'b1;
    #PERIOD_HALF clk = 1'b0;
  end

  // --- plan row builders ---
  function automatic step_row_t key_row(logic [KEY_CODE_W-1:0] code,
                                        logic [KEY_STATE_W-1:0] st);
    return '{1'b0, REG_STRIKE_LEVEL, '0, OP_KEY, code, st, 1'b0};
  endfunction

  function automatic step_row_t tick_row(logic [KEY_CODE_W-1:0] code,
                                         logic [KEY_STATE_W-1:0] st, logic zero_known);
    return '{1'b0, REG_STRIKE_LEVEL, '0, OP_TICK, code, st, zero_known};
  endfunction

  function automatic step_row_t reg_row(cfg_reg_t sel, logic [ENV_W-1:0] val);
    return '{1'b1, sel, val, OP_TICK, '0, '0, 1'b0};
  endfunction

  // --- predictor ---
  // Odd polynomial over a quarter turn, Q30 with truncating division
  function automatic int quarter_wave(longint r);
    longint u, u2, p, s, v;
    u  = r * 65536;
    u2 = (u * u) / Q30;
    p  = 172272;
    p  = -5026995 + (p * u2) / Q30;
    p  = 85569306 + (p * u2) / Q30;
    p  = -693598668 + (p * u2) / Q30;
    p  = 1686629713 + (p * u2) / Q30;
    s  = (p * u) / Q30;
    v  = (s * 32767 + Q30 / 2) / Q30;
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return int'(v);
  endfunction

  task automatic reset_model();
    longint t, r, f;
    int quad, v;
    strike_cfg = STRIKE_RESET;
    decay_cfg  = DECAY_RESET;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      t    = (longint'(i) * 65536) / SINE_DEPTH;
      quad = int'((t >> 14) & 3);
      r    = t & 16383;
      if (quad == 1 || quad == 3) r = 16384 - r;
      v = quarter_wave(r);
      sine_q15[i] = (quad >= 2) ? -v : v;
    end
    for (int n = 0; n < NUM_VOICES; n++) begin
      f = longint'(NOTE_MHZ[n]);
      env_lvl[n]   = '0;
      phase_acc[n] = '0;
      note_step[n] = PHASE_BITS'(((f << PHASE_BITS) + 4000000) / 64'sd8000000);
    end
  endtask

  function automatic int voice_for_code(logic [KEY_CODE_W-1:0] code);
    if (code >= KEY_ROW_A_FIRST && code <= KEY_ROW_A_LAST)
      return int'(code) - int'(KEY_ROW_A_FIRST);
    if (code >= KEY_ROW_B_FIRST && code <= KEY_ROW_B_LAST)
      return int'(code) - int'(KEY_ROW_B_FIRST) + int'(ROW_B_VOICE0);
    return -1;
  endfunction

  function automatic logic [KEY_CODE_W-1:0] code_for_voice(int n);
    return (n < int'(ROW_B_VOICE0)) ? KEY_CODE_W'(int'(KEY_ROW_A_FIRST) + n)
                                    : KEY_CODE_W'(int'(KEY_ROW_B_FIRST) + n - 6);
  endfunction

  // Mix all voices for one tick, then advance phases and decay envelopes
  function automatic logic [SAMPLE_W-1:0] render_tick();
    longint acc;
    logic [63:0] prod;
    int idx;
    acc = 0;
    for (int n = 0; n < NUM_VOICES; n++) begin
      idx = int'(phase_acc[n][PHASE_BITS-1 -: SINE_IDX_W]);
      acc += (longint'({33'b0, env_lvl[n]}) * longint'(sine_q15[idx])) / 32768;
      phase_acc[n] = phase_acc[n] + note_step[n];
      prod = {33'b0, env_lvl[n]} * {48'b0, decay_cfg};
      env_lvl[n] = prod[ENV_W+15:16];
    end
    if (acc > 64'sd2147483647) begin
      saturations++;
      return 32'h7FFF_FFFF;
    end
    if (acc < -64'sd2147483648) begin
      saturations++;
      return 32'h8000_0000;
    end
    return acc[SAMPLE_W-1:0];
  endfunction

  // --- reporting ---
  task automatic report_fault(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // --- driving ---
  task automatic send_request(input logic op, input logic [KEY_CODE_W-1:0] code,
                              input logic [KEY_STATE_W-1:0] st, input logic zero_known);
    logic [SAMPLE_W-1:0] sample;
    int n;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({st, code});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_TICK) begin
      ticks_sent++;
      sample = render_tick();
      sample_q.push_back(zero_known ? '0 : sample);
    end else begin
      keys_sent++;
      n = voice_for_code(code);
      if (st == KEY_PRESSED && n >= 0 && n < NUM_VOICES) begin
        env_lvl[n] = strike_cfg;
        voices_struck++;
      end
    end
  endtask

  // Bursts of back-to-back requests separated by random gaps
  task automatic idle_gap();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_samples();
    while (sample_q.size() != 0) @(posedge clk);
  endtask

  // Block idle: no request offered, every sample in, key work finished
  task automatic settle();
    in_tvalid <= 1'b0;
    drain_samples();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [ENV_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
    if (sel == REG_STRIKE_LEVEL) strike_cfg = val;
    else decay_cfg = val[DECAY_W-1:0];
  endtask

  // --- result checking ---
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sample_q.size() == 0) begin
        report_fault($sformatf("sample %0d with none expected", $signed(out_tdata)));
      end else begin
        want = sample_q.pop_front();
        samples_checked++;
        if (out_tdata !== want)
          report_fault($sformatf("audio_sample expected %0d got %0d",
                                 $signed(want), $signed(out_tdata)));
      end
    end
  end

  // --- receiver: stall patterns by phase, plus one long hold-off ---
  // The hold-off starts while the sender is offering, so the input backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_cycle   <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (rx_cycle >= HOLD_AT && !hold_done && in_tvalid) begin
        hold_left  <= HOLD_LEN;
        hold_done  <= 1'b1;
        out_tready <= 1'b0;
      end else begin
        case (rx_cycle[8:7])
          2'd0: out_tready <= 1'b1;
          2'd1: out_tready <= $urandom_range(0, 1) == 1;
          2'd2: out_tready <= $urandom_range(0, 3) == 0;
          default: out_tready <= $urandom_range(0, 7) != 0;
        endcase
      end
    end
  end

  // --- watchdog on handshake activity ---
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --- stimulus ---
  initial begin
    logic [ENV_W-1:0] strike_set [PHASES];
    logic [ENV_W-1:0] decay_set [PHASES];
    int pick;
    logic [KEY_CODE_W-1:0] code;
    logic [KEY_STATE_W-1:0] st;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_TICK;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_STRIKE_LEVEL;
    cfg_wdata <= '0;
    errors = 0; samples_checked = 0; saturations = 0; ticks_sent = 0;
    keys_sent = 0; voices_struck = 0; reg_writes = 0; burst_left = 0;
    reset_model();

    // Directed plan: mapping edges, ignored keys, extreme levels and decays
    plan = '{
      key_row(8'd3, KEY_PRESSED),          // first voice of the low row
      key_row(8'd23, KEY_PRESSED),         // last voice of the high row
      key_row(8'd5, KEY_PRESSED),          // voice with no note
      key_row(8'd2, KEY_PRESSED),          // just below the low row
      key_row(8'd24, KEY_PRESSED),         // just above the high row
      key_row(8'd255, KEY_PRESSED),        // unmapped, all code bits set
      key_row(8'd8, KEY_REPEAT),           // autorepeat ignored
      key_row(8'd16, KEY_RELEASED),        // release ignored
      tick_row(8'd0, KEY_RELEASED, 1'b1),  // all phases at zero
      tick_row(8'd255, KEY_REPEAT, 1'b0),
      tick_row(8'd0, KEY_RELEASED, 1'b0),
      reg_row(REG_STRIKE_LEVEL, 31'h7FFF_FFFF),
      reg_row(REG_DECAY_FACTOR, 31'h7FFF_FFFF),  // upper bits dropped
      key_row(8'd4, KEY_PRESSED),
      key_row(8'd17, KEY_PRESSED),
      key_row(8'd18, KEY_PRESSED),
      key_row(8'd19, KEY_PRESSED),
      key_row(8'd20, KEY_PRESSED),
      key_row(8'd21, KEY_PRESSED),
      key_row(8'd22, KEY_PRESSED),
      tick_row(8'd0, KEY_RELEASED, 1'b0),
      tick_row(8'd0, KEY_RELEASED, 1'b0),
      tick_row(8'd0, KEY_RELEASED, 1'b0),
      reg_row(REG_DECAY_FACTOR, 31'd0),
      tick_row(8'd0, KEY_RELEASED, 1'b0),
      tick_row(8'd0, KEY_RELEASED, 1'b1),  // envelopes wiped by zero decay
      key_row(8'd0, KEY_RELEASED),
      tick_row(8'd255, KEY_REPEAT, 1'b1)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].sel, plan[i].wval);
      end else begin
        send_request(plan[i].op, plan[i].code, plan[i].kstate, plan[i].zero_known);
        idle_gap();
      end
    end

    // Random phases, one strike and decay setting each
    strike_set = '{31'h7FFF_FFFF, 31'($urandom()), 31'd0, STRIKE_RESET, 31'($urandom())};
    decay_set  = '{31'h0000_FFFF, 31'($urandom()), 31'(DECAY_RESET), 31'd0,
                   31'($urandom_range(60000, 65535))};
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_reg(REG_STRIKE_LEVEL, strike_set[ph]);
      write_reg(REG_DECAY_FACTOR, decay_set[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mid-phase the sender waits for every outstanding sample
        if (n == PHASE_ITEMS / 2) begin
          in_tvalid <= 1'b0;
          drain_samples();
          @(posedge clk);
        end
        pick = $urandom_range(0, 99);
        code = KEY_CODE_W'($urandom_range(0, 255));
        st   = KEY_STATE_W'($urandom_range(0, 2));
        if (pick < 55) begin
          send_request(OP_TICK, code, st, 1'b0);
        end else if (pick < 88) begin
          send_request(OP_KEY, code_for_voice($urandom_range(0, NUM_VOICES - 1)),
                       KEY_PRESSED, 1'b0);
        end else if (pick < 95) begin
          send_request(OP_KEY, code_for_voice($urandom_range(0, NUM_VOICES - 1)),
                       ($urandom_range(0, 1) == 1) ? KEY_REPEAT : KEY_RELEASED, 1'b0);
        end else begin
          send_request(OP_KEY, code, st, 1'b0);
        end
        idle_gap();
      end
    end

    in_tvalid <= 1'b0;
    drain_samples();
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d ticks and %0d key requests (%0d struck a voice), %0d reg writes",
             ticks_sent, keys_sent, voices_struck, reg_writes);
    $display("Samples checked %0d, saturated %0d, errors %0d",
             samples_checked, saturations, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
